/* sv/tccb_pkg.sv */
// Package for the text console cell buffer: field widths, command and
// register codes, cell and result types and the sequencer states.
// Depends on nothing; every other file of the block imports it.
package tccb_pkg;

	localparam int CHAR_W     = 8;
	localparam int COLOUR_W   = 32;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 6;
	localparam int CMD_W      = 2;
	localparam int COLS_W     = 8;
	localparam int ROWS_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 64;

	localparam logic [CHAR_W-1:0]   NL_CODE    = 8'd10;
	localparam logic [CHAR_W-1:0]   SPACE_CODE = 8'h20;
	localparam logic [COLOUR_W-1:0] WHITE      = 32'hFFFF_FFFF;
	localparam logic [COLOUR_W-1:0] NO_COLOUR  = 32'h0000_0000;

	localparam logic [COLS_W-1:0] COLS_RST = 8'd80;
	localparam logic [ROWS_W-1:0] ROWS_RST = 7'd25;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLS = 2'd0,
		REG_ROWS = 2'd1,
		REG_FG   = 2'd2,
		REG_BG   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCROLL,
		S_BLANK,
		S_CLEAR,
		S_FINISH
	} seq_state_t;

	typedef struct packed {
		logic [CHAR_W-1:0]   ch;
		logic [COLOUR_W-1:0] fg;
		logic [COLOUR_W-1:0] bg;
	} cell_t;

	typedef struct packed {
		logic [COLS_W-1:0]   cols;
		logic [ROWS_W-1:0]   rows;
		logic [COLOUR_W-1:0] fg_colour;
		logic [COLOUR_W-1:0] bg_colour;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CHAR_W-1:0] char_code;
		logic [COL_W-1:0]  read_col;
		logic [ROW_W-1:0]  read_row;
	} req_t;

	typedef struct packed {
		cell_t             cell_data;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic              scrolled;
	} result_t;

endpackage

/* sv/tccb_req_if.sv */
// Command channel of the text console cell buffer: valid/ready plus payload.
// Depends on tccb_pkg for the field widths.
interface tccb_req_if;
	import tccb_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CHAR_W-1:0] char_code;
	logic [COL_W-1:0]  read_col;
	logic [ROW_W-1:0]  read_row;

	modport source (output valid, output cmd, output char_code, output read_col,
		output read_row, input ready);
	modport sink (input valid, input cmd, input char_code, input read_col,
		input read_row, output ready);
endinterface

/* sv/tccb_rsp_if.sv */
// Result channel of the text console cell buffer: valid/ready plus payload.
// Depends on tccb_pkg for the field widths.
interface tccb_rsp_if;
	import tccb_pkg::*;

	logic                valid;
	logic                ready;
	logic [CHAR_W-1:0]   cell_char;
	logic [COLOUR_W-1:0] cell_fg;
	logic [COLOUR_W-1:0] cell_bg;
	logic [COL_W-1:0]    cursor_col;
	logic [ROW_W-1:0]    cursor_row;
	logic                scrolled;

	modport source (output valid, output cell_char, output cell_fg, output cell_bg,
		output cursor_col, output cursor_row, output scrolled, input ready);
	modport sink (input valid, input cell_char, input cell_fg, input cell_bg,
		input cursor_col, input cursor_row, input scrolled, output ready);
endinterface

/* sv/tccb_cell_mem.sv */
// Cell store of the text console: one write port, one read port, registered read data.
// Depends on tccb_pkg for the cell type.
module tccb_cell_mem #(
	parameter int DEPTH = tccb_pkg::MAX_COLS_DEF * tccb_pkg::MAX_ROWS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  tccb_pkg::cell_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output tccb_pkg::cell_t rdata
);
	import tccb_pkg::*;

	cell_t mem_q [DEPTH];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* sv/tccb_seq.sv */
// Sequencer of the text console: cursor, command decode and the sweeps for
// clear, scroll and the bottom-row blank. Depends on tccb_pkg; drives tccb_cell_mem.
module tccb_seq #(
	parameter int MAX_COLS = tccb_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = tccb_pkg::MAX_ROWS_DEF,
	parameter int AW       = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tccb_pkg::cfg_t    cfg,
	input  logic              req_valid,
	input  tccb_pkg::req_t    req,
	output logic              req_ready,
	output logic              res_valid,
	input  logic              res_take,
	output tccb_pkg::result_t res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output tccb_pkg::cell_t   mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  tccb_pkg::cell_t   mem_rdata
);
	import tccb_pkg::*;

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int XW    = $clog2(MAX_COLS + 1);
	localparam int YW    = $clog2(MAX_ROWS + 1);
	localparam int AXW   = AW + XW + YW;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y,
		input logic [XW-1:0] x);
		logic [AXW-1:0] a;
		a = AXW'(y) * AXW'(MAX_COLS) + AXW'(x);
		return a[AW-1:0];
	endfunction

	seq_state_t state_q, state_d;

	logic [XW-1:0] cur_x_q;
	logic [YW-1:0] cur_y_q;
	logic [AW-1:0] clr_q;
	logic [XW-1:0] sx_q;
	logic [YW-1:0] sy_q;
	logic          rd_v_s1;
	logic [AW-1:0] wa_s1;
	logic          rd_hit_q;
	logic          scr_q;

	logic [XW-1:0] nc, cx, new_x;
	logic [YW-1:0] nr, cy, new_y;
	logic [XW:0]   x_inc;
	logic          is_nl, wrap, last_row, need_scroll, rd_hit, accept;
	logic          clr_last, sx_last, sy_last;
	logic [AW-1:0] wr_addr, rd_addr;
	cmd_t          cmd;

	// Area in use, clamped to the store, and the cursor clamped into it.
	always_comb begin
		if (cfg.cols == '0) begin
			nc = XW'(1);
		end else if ({1'b0, cfg.cols} > 9'(MAX_COLS)) begin
			nc = XW'(MAX_COLS);
		end else begin
			nc = XW'(cfg.cols);
		end
		if (cfg.rows == '0) begin
			nr = YW'(1);
		end else if ({1'b0, cfg.rows} > 8'(MAX_ROWS)) begin
			nr = YW'(MAX_ROWS);
		end else begin
			nr = YW'(cfg.rows);
		end
		cx = (cur_x_q >= nc) ? nc - XW'(1) : cur_x_q;
		cy = (cur_y_q >= nr) ? nr - YW'(1) : cur_y_q;
	end

	// Cursor step for a write command.
	always_comb begin
		cmd         = cmd_t'(req.cmd);
		is_nl       = (req.char_code == NL_CODE);
		x_inc       = {1'b0, cx} + (XW+1)'(1);
		wrap        = is_nl || (x_inc >= {1'b0, nc});
		last_row    = (({1'b0, cy} + (YW+1)'(1)) >= {1'b0, nr});
		need_scroll = wrap && last_row;
		new_x       = wrap ? '0 : x_inc[XW-1:0];
		if (!wrap) begin
			new_y = cy;
		end else if (last_row) begin
			new_y = nr - YW'(1);
		end else begin
			new_y = cy + YW'(1);
		end
		wr_addr = cell_addr(cy, cx);
		rd_hit  = (9'(req.read_col) < 9'(nc)) && (8'(req.read_row) < 8'(nr));
		rd_addr = cell_addr(YW'(req.read_row), XW'(req.read_col));
		accept  = req_valid && req_ready;
	end

	assign clr_last = (clr_q == LAST_CELL);
	assign sx_last  = (({1'b0, sx_q} + (XW+1)'(1)) >= {1'b0, nc});
	assign sy_last  = (({1'b0, sy_q} + (YW+1)'(1)) >= {1'b0, nr});

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					case (cmd)
						CMD_WRITE: begin
							if (!need_scroll) begin
								state_d = S_FINISH;
							end else if (nr > YW'(1)) begin
								state_d = S_SCROLL;
							end else begin
								state_d = S_BLANK;
							end
						end
						CMD_CLEAR: state_d = S_CLEAR;
						default:   state_d = S_FINISH;
					endcase
				end
			end
			S_SCROLL: begin
				if (sx_last && sy_last) state_d = S_BLANK;
			end
			S_BLANK: begin
				if (!rd_v_s1 && sx_last) state_d = S_FINISH;
			end
			S_CLEAR: begin
				if (clr_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (res_take) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	// Memory port control and handshake outputs.
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_INIT, S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '{ch: SPACE_CODE, fg: WHITE, bg: NO_COLOUR};
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (accept && cmd == CMD_WRITE && !is_nl) begin
					mem_we    = 1'b1;
					mem_waddr = wr_addr;
					mem_wdata = '{ch: req.char_code, fg: cfg.fg_colour, bg: cfg.bg_colour};
				end
				if (accept && cmd == CMD_READ) begin
					mem_re    = 1'b1;
					mem_raddr = rd_addr;
				end
			end
			S_SCROLL: begin
				mem_re    = 1'b1;
				mem_raddr = cell_addr(sy_q, sx_q);
				if (rd_v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = wa_s1;
					mem_wdata = mem_rdata;
				end
			end
			S_BLANK: begin
				mem_we = 1'b1;
				if (rd_v_s1) begin
					mem_waddr = wa_s1;
					mem_wdata = mem_rdata;
				end else begin
					mem_waddr = cell_addr(nr - YW'(1), sx_q);
					mem_wdata = '{ch: SPACE_CODE, fg: NO_COLOUR, bg: NO_COLOUR};
				end
			end
			S_FINISH: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			clr_q    <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			rd_v_s1  <= 1'b0;
			rd_hit_q <= 1'b0;
			scr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == S_SCROLL);

			if (state_q == S_INIT || state_q == S_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + AW'(1);
			end

			if (accept) begin
				rd_hit_q <= (cmd == CMD_READ) && rd_hit;
				scr_q    <= (cmd == CMD_WRITE) && need_scroll;
				case (cmd)
					CMD_WRITE: begin
						cur_x_q <= new_x;
						cur_y_q <= new_y;
						sx_q    <= '0;
						sy_q    <= YW'(1);
					end
					CMD_CLEAR: begin
						cur_x_q <= '0;
						cur_y_q <= '0;
					end
					default: begin
					end
				endcase
			end

			if (state_q == S_SCROLL) begin
				if (sx_last) begin
					sx_q <= '0;
					if (!sy_last) sy_q <= sy_q + YW'(1);
				end else begin
					sx_q <= sx_q + XW'(1);
				end
			end else if (state_q == S_BLANK && !rd_v_s1) begin
				sx_q <= sx_last ? '0 : sx_q + XW'(1);
			end
		end
	end

	// The copy writes one row above the cell just read.
	always_ff @(posedge clk) begin
		wa_s1 <= cell_addr(sy_q - YW'(1), sx_q);
	end

	always_comb begin
		res.cell_data  = rd_hit_q ? mem_rdata : '0;
		res.cursor_col = COL_W'(cur_x_q);
		res.cursor_row = ROW_W'(cur_y_q);
		res.scrolled   = scr_q;
	end
endmodule

/* sv/text_console_cell_buffer_top.sv */
// Top level of the text console cell buffer: configuration registers, the
// result register and the cell store. Depends on tccb_pkg, tccb_req_if,
// tccb_rsp_if, tccb_cell_mem and tccb_seq.
//
// Commands arrive on the req channel (write character, clear, read cell);
// each one produces exactly one result on the rsp channel, carrying the read
// cell (zero unless a read hit the area in use), the cursor after the command
// and a flag that tells whether the screen scrolled.
// An ordinary write, a read or a no-op passes through the finish state
// before the next command can be taken; the result is then registered in
// the output register. A write that scrolls walks the used area once
// through the single read port and single write port of the cell store;
// with one row in use it only blanks that row. A clear walks the whole store.
// After reset the store is blanked by a pass over all MAX_COLS*MAX_ROWS
// cells (8192 with the default sizes); ready stays low until it ends, while
// configuration writes are taken at any time.
// When the receiver stalls, a finished result waits in the output register;
// the next command can still be taken and is held back at its end until the
// register frees up.
module text_console_cell_buffer_top #(
	parameter int MAX_COLS = tccb_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = tccb_pkg::MAX_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [tccb_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [tccb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	tccb_req_if.sink                          req,
	tccb_rsp_if.source                        rsp
);
	import tccb_pkg::*;

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	cfg_t    cfg_q;
	req_t    req_pl;
	result_t res;
	result_t out_q;
	logic    out_valid_q;
	logic    req_ready, res_valid, res_take;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	cell_t         mem_wdata, mem_rdata;

	// Configuration registers, written at the next edge. The sender must issue
	// writes only while no command is in flight; the block does not check it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols      <= COLS_RST;
			cfg_q.rows      <= ROWS_RST;
			cfg_q.fg_colour <= WHITE;
			cfg_q.bg_colour <= NO_COLOUR;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_idx))
				REG_COLS: cfg_q.cols      <= cfg_wdata[COLS_W-1:0];
				REG_ROWS: cfg_q.rows      <= cfg_wdata[ROWS_W-1:0];
				REG_FG:   cfg_q.fg_colour <= cfg_wdata[COLOUR_W-1:0];
				REG_BG:   cfg_q.bg_colour <= cfg_wdata[COLOUR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req_pl.cmd       = req.cmd;
	assign req_pl.char_code = req.char_code;
	assign req_pl.read_col  = req.read_col;
	assign req_pl.read_row  = req.read_row;
	assign req.ready        = req_ready;

	// The sequencer hands over its result once the output register is free
	// or is being emptied in the same cycle.
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cell_char  = out_q.cell_data.ch;
	assign rsp.cell_fg    = out_q.cell_data.fg;
	assign rsp.cell_bg    = out_q.cell_data.bg;
	assign rsp.cursor_col = out_q.cursor_col;
	assign rsp.cursor_row = out_q.cursor_row;
	assign rsp.scrolled   = out_q.scrolled;

	tccb_seq #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.AW       (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req.valid),
		.req       (req_pl),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tccb_cell_mem #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);
endmodule

/* tb/tb.sv */
// Self-checking testbench for text_console_cell_buffer_top: a short directed
// table followed by random command streams under several register settings.
// Depends on tccb_pkg, tccb_req_if, tccb_rsp_if and the block's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tccb_pkg::*;

	localparam int MAX_COLS  = MAX_COLS_DEF;
	localparam int MAX_ROWS  = MAX_ROWS_DEF;
	localparam int CELLS     = MAX_COLS * MAX_ROWS;
	// The limit must cover a clear or a scroll of the largest area and the
	// blanking pass after reset, each of which walks the whole store.
	localparam int WATCHDOG_LIMIT = 40000;

	// Results that need no predictor: blank cell at the home position, and
	// all-zero fields with the cursor at home.
	localparam result_t BLANK_AT_HOME = {SPACE_CODE, WHITE, NO_COLOUR, 7'd0, 6'd0, 1'b0};
	localparam result_t ZERO_AT_HOME  = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tccb_req_if req_ch ();
	tccb_rsp_if rsp_ch ();

	text_console_cell_buffer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Screen model. It mirrors the store and the cursor of the block and
	// works out the result of each command at the moment it is accepted.
	// ------------------------------------------------------------------
	logic [CHAR_W-1:0]   text_mem [CELLS];
	logic [COLOUR_W-1:0] fg_mem   [CELLS];
	logic [COLOUR_W-1:0] bg_mem   [CELLS];
	int unsigned         cur_x;
	int unsigned         cur_y;

	logic [COLS_W-1:0]   reg_cols;
	logic [ROWS_W-1:0]   reg_rows;
	logic [COLOUR_W-1:0] reg_fg;
	logic [COLOUR_W-1:0] reg_bg;

	// A zero size counts as one, and sizes above the store are cut down to it.
	function automatic int unsigned used_width();
		if (reg_cols == 0) return 1;
		if (reg_cols > MAX_COLS) return MAX_COLS;
		return reg_cols;
	endfunction

	function automatic int unsigned used_height();
		if (reg_rows == 0) return 1;
		if (reg_rows > MAX_ROWS) return MAX_ROWS;
		return reg_rows;
	endfunction

	// Clear touches the whole store, not just the area in use.
	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++) begin
			text_mem[i] = SPACE_CODE;
			fg_mem[i]   = WHITE;
			bg_mem[i]   = NO_COLOUR;
		end
		cur_x = 0;
		cur_y = 0;
	endfunction

	// Rows move up by one inside the area in use; the freed bottom row is
	// blanked with zero colours, unlike a clear.
	function automatic void scroll_screen(int unsigned nc, int unsigned nr);
		int unsigned dst;
		for (int unsigned r = 0; r + 1 < nr; r++)
			for (int unsigned c = 0; c < nc; c++) begin
				dst = r * MAX_COLS + c;
				text_mem[dst] = text_mem[dst + MAX_COLS];
				fg_mem[dst]   = fg_mem[dst + MAX_COLS];
				bg_mem[dst]   = bg_mem[dst + MAX_COLS];
			end
		for (int unsigned c = 0; c < nc; c++) begin
			dst = (nr - 1) * MAX_COLS + c;
			text_mem[dst] = SPACE_CODE;
			fg_mem[dst]   = NO_COLOUR;
			bg_mem[dst]   = NO_COLOUR;
		end
	endfunction

	function automatic bit line_feed(int unsigned nc, int unsigned nr);
		cur_x = 0;
		cur_y++;
		if (cur_y >= nr) begin
			cur_y = nr - 1;
			scroll_screen(nc, nr);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic result_t console_apply(req_t item);
		result_t     res;
		int unsigned nc;
		int unsigned nr;
		int unsigned addr;
		nc  = used_width();
		nr  = used_height();
		res = '0;
		case (cmd_t'(item.cmd))
			CMD_WRITE: begin
				// The area may have shrunk under the cursor since the last write.
				if (cur_x >= nc) cur_x = nc - 1;
				if (cur_y >= nr) cur_y = nr - 1;
				if (item.char_code == NL_CODE) begin
					res.scrolled = line_feed(nc, nr);
				end else begin
					addr = cur_y * MAX_COLS + cur_x;
					text_mem[addr] = item.char_code;
					fg_mem[addr]   = reg_fg;
					bg_mem[addr]   = reg_bg;
					cur_x++;
					if (cur_x >= nc) res.scrolled = line_feed(nc, nr);
				end
			end
			CMD_CLEAR: blank_screen();
			CMD_READ: begin
				if (item.read_col < nc && item.read_row < nr) begin
					addr = item.read_row * MAX_COLS + item.read_col;
					res.cell_data.ch = text_mem[addr];
					res.cell_data.fg = fg_mem[addr];
					res.cell_data.bg = bg_mem[addr];
				end
			end
			default: ;
		endcase
		res.cursor_col = cur_x[COL_W-1:0];
		res.cursor_row = cur_y[ROW_W-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Expected results, oldest first, and the failure count.
	// ------------------------------------------------------------------
	result_t pending_results [$];
	int      fail_count = 0;
	// When set, both sides drive back to back with no idle cycles.
	bit      calm = 1'b0;

	// Drops the command valid first, so that the last command is not
	// presented again while the block drains.
	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Register writes happen only with no command outstanding, so the model
	// can take the new value at once.
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		wait_drained();
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_COLS: reg_cols = data[COLS_W-1:0];
			REG_ROWS: reg_rows = data[ROWS_W-1:0];
			REG_FG:   reg_fg   = data;
			REG_BG:   reg_bg   = data;
			default: ;
		endcase
	endtask

	// Presents one command after a random number of idle cycles and waits
	// for its transfer. The expectation is pushed at the transfer edge, before
	// the block can register its result. A typed result,
	// where given, stands in for the predicted one, but the model still
	// steps so that its state follows the block.
	task automatic send_command(req_t item, bit typed, result_t want);
		int unsigned gap;
		result_t     predicted;
		gap = calm ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
		@(negedge clk);
		req_ch.valid     = 1'b1;
		req_ch.cmd       = item.cmd;
		req_ch.char_code = item.char_code;
		req_ch.read_col  = item.read_col;
		req_ch.read_row  = item.read_row;
		do @(posedge clk); while (!req_ch.ready);
		predicted = console_apply(item);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// ------------------------------------------------------------------
	// Directed table. Rows are either a register write or a command; a few
	// commands carry a result typed in by hand.
	// ------------------------------------------------------------------
	typedef struct {
		bit                    is_reg;
		cfg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		req_t                  item;
		bit                    typed;
		result_t               want;
	} plan_row_t;

	plan_row_t directed_plan [$];

	task automatic plan_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row        = '{idx: REG_COLS, default: '0};
		row.is_reg = 1'b1;
		row.idx    = idx;
		row.data   = data;
		directed_plan.push_back(row);
	endtask

	task automatic plan_cmd(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] col,
		logic [ROW_W-1:0] row_no, bit typed = 1'b0, result_t want = '0);
		plan_row_t row;
		row       = '{idx: REG_COLS, default: '0};
		row.item  = {cmd, ch, col, row_no};
		row.typed = typed;
		row.want  = want;
		directed_plan.push_back(row);
	endtask

	task automatic build_directed_plan();
		// Straight after reset: 80 x 25 area, blank white-on-zero cells.
		plan_cmd(CMD_READ, 8'h00, 7'd0,   6'd0,  1'b1, BLANK_AT_HOME);
		plan_cmd(CMD_READ, 8'h00, 7'd79,  6'd24, 1'b1, BLANK_AT_HOME);
		// Reads just past the area in use and at the far corner of the store.
		plan_cmd(CMD_READ, 8'h00, 7'd80,  6'd0,  1'b1, ZERO_AT_HOME);
		plan_cmd(CMD_READ, 8'h00, 7'd0,   6'd25, 1'b1, ZERO_AT_HOME);
		plan_cmd(CMD_READ, 8'hFF, 7'd127, 6'd63, 1'b1, ZERO_AT_HOME);
		// The unused command code leaves everything alone.
		plan_cmd(CMD_NOP,  8'hFF, 7'd127, 6'd63, 1'b1, ZERO_AT_HOME);
		plan_cmd(CMD_WRITE, 8'hFF, 7'd0, 6'd0);
		plan_cmd(CMD_WRITE, 8'h00, 7'd0, 6'd0);
		plan_reg(REG_FG, NO_COLOUR);
		plan_reg(REG_BG, WHITE);
		plan_cmd(CMD_WRITE, 8'h55, 7'd0, 6'd0);
		plan_cmd(CMD_READ,  8'h00, 7'd2, 6'd0);
		plan_cmd(CMD_WRITE, NL_CODE, 7'd0, 6'd0);
		// A 3 x 2 area: wrapping at the last column and scrolling at the
		// last row, both by a full line and by a newline.
		plan_reg(REG_COLS, 32'd3);
		plan_reg(REG_ROWS, 32'd2);
		plan_cmd(CMD_WRITE, 8'h61, 7'd0, 6'd0);
		plan_cmd(CMD_WRITE, 8'h62, 7'd0, 6'd0);
		plan_cmd(CMD_WRITE, 8'h63, 7'd0, 6'd0);
		plan_cmd(CMD_WRITE, 8'h64, 7'd0, 6'd0);
		plan_cmd(CMD_WRITE, NL_CODE, 7'd0, 6'd0);
		plan_cmd(CMD_READ,  8'h00, 7'd0, 6'd0);
		plan_cmd(CMD_READ,  8'h00, 7'd0, 6'd1);
		// Zero sizes act as one: the cursor is pulled back into the single
		// cell and the write scrolls at once.
		plan_reg(REG_COLS, 32'd0);
		plan_reg(REG_ROWS, 32'd0);
		plan_cmd(CMD_WRITE, 8'h7A, 7'd0, 6'd0);
		// Oversized registers stand for the whole store; a clear then blanks
		// every cell, the far corner among them.
		plan_reg(REG_COLS, 32'd255);
		plan_reg(REG_ROWS, 32'd127);
		plan_cmd(CMD_READ,  8'h00, 7'd0,   6'd0);
		plan_cmd(CMD_CLEAR, 8'h00, 7'd0,   6'd0,  1'b1, ZERO_AT_HOME);
		plan_cmd(CMD_READ,  8'h00, 7'd127, 6'd63, 1'b1, BLANK_AT_HOME);
	endtask

	// Random command. Reads mostly land inside the area in use; fields that
	// a command does not use still carry random bits.
	function automatic req_t random_command(bit newline_heavy);
		req_t        item;
		int unsigned pick;
		item.char_code = ($urandom_range(0, 9) == 0) ? NL_CODE : CHAR_W'($urandom);
		item.read_col  = COL_W'($urandom);
		item.read_row  = ROW_W'($urandom);
		pick = $urandom_range(0, 99);
		if (newline_heavy) begin
			item.cmd = (pick < 85) ? CMD_WRITE : CMD_READ;
			if (pick < 85) item.char_code = NL_CODE;
		end else if (pick < 1) begin
			item.cmd = CMD_CLEAR;
		end else if (pick < 4) begin
			item.cmd = CMD_NOP;
		end else if (pick < 26) begin
			item.cmd = CMD_READ;
		end else begin
			item.cmd = CMD_WRITE;
		end
		if (item.cmd == CMD_READ && $urandom_range(0, 3) != 0) begin
			item.read_col = COL_W'($urandom_range(0, used_width() - 1));
			item.read_row = ROW_W'($urandom_range(0, used_height() - 1));
		end
		return item;
	endfunction

	// ------------------------------------------------------------------
	// Result side: draw a stall, raise ready, then check the transfer
	// against the oldest expectation, field by field.
	// ------------------------------------------------------------------
	initial begin : result_checker
		int unsigned stall;
		result_t     want;
		rsp_ch.ready = 1'b0;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				@(negedge clk);
				rsp_ch.ready = 1'b0;
			end
			@(negedge clk);
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (pending_results.size() == 0) begin
				$error("result transfer with no command outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.cell_char !== want.cell_data.ch) begin
					$error("cell_char: expected %h, got %h", want.cell_data.ch,
						rsp_ch.cell_char);
					fail_count++;
				end
				if (rsp_ch.cell_fg !== want.cell_data.fg) begin
					$error("cell_fg: expected %h, got %h", want.cell_data.fg,
						rsp_ch.cell_fg);
					fail_count++;
				end
				if (rsp_ch.cell_bg !== want.cell_data.bg) begin
					$error("cell_bg: expected %h, got %h", want.cell_data.bg,
						rsp_ch.cell_bg);
					fail_count++;
				end
				if (rsp_ch.cursor_col !== want.cursor_col) begin
					$error("cursor_col: expected %0d, got %0d", want.cursor_col,
						rsp_ch.cursor_col);
					fail_count++;
				end
				if (rsp_ch.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", want.cursor_row,
						rsp_ch.cursor_row);
					fail_count++;
				end
				if (rsp_ch.scrolled !== want.scrolled) begin
					$error("scrolled: expected %b, got %b", want.scrolled, rsp_ch.scrolled);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: counts cycles with no transfer on either channel. The
	// blanking pass after reset, a clear and a scroll of the largest area
	// each walk the whole store without one.
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, the directed table, then random phases. Each
	// phase rewrites all four registers once the block has drained.
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned       phase_items;
		logic [COLS_W-1:0] new_cols;
		logic [ROWS_W-1:0] new_rows;
		logic [COLOUR_W-1:0] new_fg;
		logic [COLOUR_W-1:0] new_bg;

		arst_n           = 1'b0;
		cfg_wen          = 1'b0;
		cfg_idx          = '0;
		cfg_wdata        = '0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = '0;
		req_ch.char_code = '0;
		req_ch.read_col  = '0;
		req_ch.read_row  = '0;

		// Reset values of the registers; the store comes out of reset as if
		// cleared.
		reg_cols = COLS_RST;
		reg_rows = ROWS_RST;
		reg_fg   = WHITE;
		reg_bg   = NO_COLOUR;
		blank_screen();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The first command waits out the blanking pass on ready alone.
		build_directed_plan();
		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_reg)
				write_reg(directed_plan[i].idx, directed_plan[i].data);
			else
				send_command(directed_plan[i].item, directed_plan[i].typed,
					directed_plan[i].want);
		end

		for (int p = 0; p < 12; p++) begin
			new_fg = COLOUR_W'($urandom);
			new_bg = COLOUR_W'($urandom);
			case (p)
				0: begin
					// Single cell: every printable write scrolls.
					new_cols = 8'd1;
					new_rows = 7'd1;
					new_fg   = NO_COLOUR;
					new_bg   = WHITE;
				end
				1: begin
					// Whole store, driven with newlines so that it scrolls
					// a few times at full size.
					new_cols = 8'd255;
					new_rows = 7'd127;
				end
				2: begin
					new_cols = 8'd0;
					new_rows = 7'd0;
					new_fg   = WHITE;
					new_bg   = NO_COLOUR;
				end
				3: begin
					new_cols = 8'd128;
					new_rows = 7'd2;
				end
				4: begin
					new_cols = 8'd2;
					new_rows = 7'd64;
				end
				default: begin
					new_cols = COLS_W'($urandom_range(1, 12));
					new_rows = ROWS_W'($urandom_range(1, 6));
				end
			endcase
			write_reg(REG_COLS, CFG_DATA_W'(new_cols));
			write_reg(REG_ROWS, CFG_DATA_W'(new_rows));
			write_reg(REG_FG, new_fg);
			write_reg(REG_BG, new_bg);

			// Every fourth phase runs back to back on both sides.
			calm = (p % 4 == 3);
			phase_items = (p == 1) ? 80 : 85;
			for (int k = 0; k < phase_items; k++) begin
				// Once, the sender holds off mid-stream until the block
				// has handed back everything it owes.
				if (p == 5 && k == 40) wait_drained();
				send_command(random_command(p == 1), 1'b0, '0);
			end
		end

		@(negedge clk);
		req_ch.valid = 1'b0;
		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
